### design/krt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// krt_pkg: shared types and codes for the keyed record table
// Request and result words, mode and status codes.
// ----------------------------------------------------------------------------
package krt_pkg;
	localparam int MaxEntries = 256;

	localparam int KeyW = 32;
	localparam int ValW = 16;
	localparam int CntW = 9;
	localparam int CmpW = 10;

	localparam logic [2:0] MODE_INSERT = 3'd0;
	localparam logic [2:0] MODE_REMOVE = 3'd1;
	localparam logic [2:0] MODE_MODIFY = 3'd2;
	localparam logic [2:0] MODE_FIND   = 3'd3;
	localparam logic [2:0] MODE_SORT   = 3'd4;
	localparam logic [2:0] MODE_CLEAR  = 3'd5;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_MISSING = 2'd1;
	localparam logic [1:0] ST_ZERO    = 2'd2;
	localparam logic [1:0] ST_FULL    = 2'd3;

	localparam logic CFG_INIT_CAP  = 1'b0;
	localparam logic CFG_GROW_STEP = 1'b1;

	typedef struct packed {
		logic [2:0]      mode;
		logic [KeyW-1:0] key;
		logic [ValW-1:0] value;
	} req_t;

	typedef struct packed {
		logic [1:0]      status;
		logic [ValW-1:0] found_value;
		logic [CmpW-1:0] comparisons;
		logic [CntW-1:0] entry_count;
		logic [CntW-1:0] capacity;
	} rsp_t;
endpackage : krt_pkg
`default_nettype wire

### design/keyed_record_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// keyed_record_table: dictionary of unique keys with 16-bit values
// Sequencer around one record memory and one key comparator.
// ----------------------------------------------------------------------------
// Request word (req) is taken on a clk edge with start high and busy low.
// busy stays high while the request runs; the result word is shown on rsp
// with done high for exactly one cycle, the same cycle in which busy falls, and the
// next word may already be taken in that cycle. The receiver cannot stall.
// Config writes (cfg_we, cfg_index, cfg_data) are taken at any edge and
// should only happen while busy is low.
// States while busy; one memory read port is shared by every walk:
//   - each probe takes an address state, then a compare of registered data;
//     up to N probes linear, up to log2(N) + 1 binary when sorted
//   - search, then the act state; then an append for an insert, or a read
//     and a write to fetch a found value or move the last record into a hole
//   - sort: read j-1, read j, compare per check, write-back per swap, quadratic in N
//   - zero-input insert/modify, short sort, clear, unused modes: done state only
// Reset: entry count and sorted flag clear, capacity 16, grow step 16; the
// memory is not cleared since only slots below the entry count are read.
// ----------------------------------------------------------------------------
module keyed_record_table (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	output logic                           busy,
	input  wire krt_pkg::req_t             req,
	output logic                           done,
	output krt_pkg::rsp_t                  rsp,
	input  wire logic                      cfg_we,
	input  wire logic                      cfg_index,
	input  wire logic [krt_pkg::CntW-1:0]  cfg_data
);
	import krt_pkg::*;

	localparam int AW = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;
	localparam int NW = $clog2(MaxEntries + 1);
	localparam logic [NW-1:0] MaxN = NW'(MaxEntries);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_RD    = 4'd1;  // probe address issued
	localparam logic [3:0] S_CMP   = 4'd2;  // compare probe data
	localparam logic [3:0] S_ACT   = 4'd3;  // act on search outcome
	localparam logic [3:0] S_MVRD  = 4'd4;  // find: read slot, remove: read last slot
	localparam logic [3:0] S_MVWR  = 4'd5;  // append, move or value capture
	localparam logic [3:0] S_SRDA  = 4'd6;  // sort: read j-1
	localparam logic [3:0] S_SRDB  = 4'd7;  // sort: read j
	localparam logic [3:0] S_SCMP  = 4'd8;
	localparam logic [3:0] S_SWB   = 4'd9;  // write second half of swap
	localparam logic [3:0] S_DONE  = 4'd10;

	logic [3:0]      state_q;
	req_t            req_q;
	logic [NW-1:0]   used_q, cap_q;
	logic [CntW-1:0] init_cap_q, step_q;
	logic            sorted_q;
	logic [NW-1:0]   lo_q, hi_q, idx_q, j_q, s_q;
	logic [CmpW-1:0] cmp_q;
	logic            bin_q, first_q;
	logic [1:0]      status_q;
	logic [ValW-1:0] fval_q;
	logic [KeyW-1:0] ka_q;
	logic [ValW-1:0] va_q;

	logic            we;
	logic [AW-1:0]   waddr, raddr;
	logic [KeyW-1:0] wkey, rkey;
	logic [ValW-1:0] wval, rval;

	krt_store #(.Depth(MaxEntries), .AW(AW)) u_store (
		.clk, .we, .waddr, .wkey, .wval, .raddr, .rkey, .rval
	);

	// clamp helper for capacity values
	function automatic logic [NW-1:0] clamp(input logic [NW:0] v);
		return (v > {1'b0, MaxN}) ? MaxN : v[NW-1:0];
	endfunction

	// capacity an insert sees: grown by one step when the table is full
	logic [NW-1:0] grown_cap;
	assign grown_cap = (cap_q <= used_q) ? clamp({1'b0, cap_q} + (NW+1)'(step_q)) : cap_q;

	// write port and read address mux
	always_comb begin
		we    = 1'b0;
		waddr = '0;
		wkey  = req_q.key;
		wval  = req_q.value;
		raddr = idx_q[AW-1:0];
		case (state_q)
			S_ACT: begin
				if (req_q.mode == MODE_MODIFY && status_q == ST_OK) begin
					we    = 1'b1;
					waddr = idx_q[AW-1:0];
				end
			end
			S_MVRD: begin
				if (req_q.mode == MODE_REMOVE) raddr = AW'(used_q - 1'b1);
			end
			S_MVWR: begin
				if (req_q.mode == MODE_INSERT) begin
					we    = 1'b1;
					waddr = used_q[AW-1:0];
				end else if (req_q.mode == MODE_REMOVE) begin
					// last record into the hole
					we    = 1'b1;
					waddr = idx_q[AW-1:0];
					wkey  = rkey;
					wval  = rval;
				end
			end
			S_SRDA: raddr = AW'(j_q - 1'b1);
			S_SRDB: raddr = j_q[AW-1:0];
			S_SCMP: begin
				// key j lower: write old j-1 record into slot j
				we    = (rkey < ka_q);
				waddr = j_q[AW-1:0];
				wkey  = ka_q;
				wval  = va_q;
			end
			S_SWB: begin
				we    = 1'b1;
				waddr = AW'(j_q - 1'b1);
				wkey  = ka_q;
				wval  = va_q;
			end
			default: ;
		endcase
	end

	assign busy = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			used_q     <= '0;
			cap_q      <= clamp((NW+1)'(16));
			init_cap_q <= CntW'(16);
			step_q     <= CntW'(16);
			sorted_q   <= 1'b0;
			done       <= 1'b0;
			req_q      <= '0;
			status_q   <= ST_OK;
			fval_q     <= '0;
			cmp_q      <= '0;
			lo_q       <= '0;
			hi_q       <= '0;
			idx_q      <= '0;
			j_q        <= '0;
			s_q        <= '0;
			bin_q      <= 1'b0;
			first_q    <= 1'b0;
			ka_q       <= '0;
			va_q       <= '0;
		end else begin
			done <= 1'b0;
			if (cfg_we) begin
				if (cfg_index == CFG_INIT_CAP) begin
					init_cap_q <= cfg_data;
					if (used_q == '0) cap_q <= clamp((NW+1)'(cfg_data));
				end else begin
					step_q <= cfg_data;
				end
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						req_q    <= req;
						status_q <= ST_OK;
						fval_q   <= '0;
						cmp_q    <= '0;
						lo_q     <= '0;
						hi_q     <= used_q;
						idx_q    <= '0;
						bin_q    <= sorted_q;
						first_q  <= 1'b1;
						if (req.mode == MODE_SORT) begin
							s_q     <= NW'(1);
							j_q     <= NW'(1);
							state_q <= (used_q > NW'(1)) ? S_SRDA : S_DONE;
							if (used_q <= NW'(1)) sorted_q <= 1'b1;
						end else if (req.mode == MODE_CLEAR) begin
							used_q   <= '0;
							cap_q    <= '0;
							sorted_q <= 1'b0;
							state_q  <= S_DONE;
						end else if (req.mode > MODE_CLEAR) begin
							state_q <= S_DONE;
						end else if ((req.mode == MODE_INSERT || req.mode == MODE_MODIFY)
								&& (req.key == '0 || req.value == '0)) begin
							status_q <= ST_ZERO;
							state_q  <= S_DONE;
						end else if (used_q == '0) begin
							status_q <= ST_MISSING;
							state_q  <= S_ACT;
						end else begin
							state_q <= S_RD;
							idx_q   <= sorted_q ? (used_q >> 1) : '0;
						end
					end
				end
				S_RD: state_q <= S_CMP;
				S_CMP: begin
					if (rkey == req_q.key) begin
						cmp_q   <= cmp_q + 1'b1;
						state_q <= S_ACT;
					end else if (!bin_q) begin
						cmp_q <= cmp_q + 1'b1;
						if (idx_q + 1'b1 >= used_q) begin
							status_q <= ST_MISSING;
							state_q  <= S_ACT;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= S_RD;
						end
					end else begin
						cmp_q <= cmp_q + CmpW'(2);
						if (rkey > req_q.key) begin
							hi_q <= idx_q;
							if (lo_q >= idx_q) begin
								status_q <= ST_MISSING;
								state_q  <= S_ACT;
							end else begin
								idx_q   <= lo_q + ((idx_q - lo_q) >> 1);
								state_q <= S_RD;
							end
						end else begin
							lo_q <= idx_q + 1'b1;
							if (idx_q + 1'b1 >= hi_q) begin
								status_q <= ST_MISSING;
								state_q  <= S_ACT;
							end else begin
								idx_q   <= (idx_q + 1'b1) + ((hi_q - idx_q - 1'b1) >> 1);
								state_q <= S_RD;
							end
						end
					end
				end
				S_ACT: begin
					state_q <= S_DONE;
					if (req_q.mode != MODE_FIND) cmp_q <= '0;
					case (req_q.mode)
						MODE_INSERT: begin
							if (status_q == ST_OK) begin
								status_q <= ST_MISSING;  // duplicate key
							end else begin
								// key absent: grow if needed, then append
								cap_q <= grown_cap;
								if (grown_cap <= used_q || used_q >= MaxN) begin
									status_q <= ST_FULL;
								end else begin
									status_q <= ST_OK;
									state_q  <= S_MVWR;
								end
							end
						end
						MODE_REMOVE, MODE_FIND: begin
							if (status_q == ST_OK) state_q <= S_MVRD;
						end
						default: ;
					endcase
				end
				S_MVRD: state_q <= S_MVWR;
				S_MVWR: begin
					state_q <= S_DONE;
					if (req_q.mode == MODE_FIND) begin
						fval_q <= rval;
					end else if (req_q.mode == MODE_REMOVE) begin
						if (idx_q != used_q - 1'b1) sorted_q <= 1'b0;
						used_q <= used_q - 1'b1;
						if ({1'b0, cap_q} >= (NW+1)'(step_q) &&
								{1'b0, cap_q} - {1'b0, used_q - 1'b1} >= (NW+1)'(step_q))
							cap_q <= NW'({1'b0, cap_q} - (NW+1)'(step_q));
					end else begin
						used_q   <= used_q + 1'b1;
						sorted_q <= 1'b0;
						status_q <= ST_OK;
					end
				end
				S_SRDA: state_q <= S_SRDB;
				S_SRDB: begin
					state_q <= S_SCMP;
					ka_q    <= rkey;
					va_q    <= rval;
				end
				S_SCMP: begin
					if (rkey < ka_q) begin
						if (first_q) cmp_q <= cmp_q + CmpW'(2);
						ka_q    <= rkey;
						va_q    <= rval;
						first_q <= 1'b0;
						state_q <= S_SWB;
					end else begin
						// in order: the first check of a position counts one, or two
						// when the keys are equal
						if (first_q)
							cmp_q <= cmp_q + ((ka_q == rkey) ? CmpW'(2) : CmpW'(1));
						if (s_q + 1'b1 >= used_q) begin
							sorted_q <= 1'b1;
							state_q  <= S_DONE;
						end else begin
							s_q     <= s_q + 1'b1;
							j_q     <= s_q + 1'b1;
							first_q <= 1'b1;
							state_q <= S_SRDA;
						end
					end
				end
				S_SWB: begin
					if (j_q > NW'(1)) begin
						j_q     <= j_q - 1'b1;
						state_q <= S_SRDA;
					end else if (s_q + 1'b1 >= used_q) begin
						sorted_q <= 1'b1;
						state_q  <= S_DONE;
					end else begin
						s_q     <= s_q + 1'b1;
						j_q     <= s_q + 1'b1;
						first_q <= 1'b1;
						state_q <= S_SRDA;
					end
				end
				S_DONE: begin
					done    <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		rsp.status      = status_q;
		rsp.found_value = fval_q;
		rsp.comparisons = cmp_q;
		rsp.entry_count = CntW'(used_q);
		rsp.capacity    = CntW'(cap_q);
	end
endmodule : keyed_record_table
`default_nettype wire

### design/krt_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// krt_store: record memory
// One key/value memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module krt_store #(
	parameter int Depth = 256,
	parameter int AW = 8
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [AW-1:0]            waddr,
	input  wire logic [krt_pkg::KeyW-1:0] wkey,
	input  wire logic [krt_pkg::ValW-1:0] wval,
	input  wire logic [AW-1:0]            raddr,
	output logic      [krt_pkg::KeyW-1:0] rkey,
	output logic      [krt_pkg::ValW-1:0] rval
);
	import krt_pkg::*;

	logic [KeyW+ValW-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= {wkey, wval};
		end
		{rkey, rval} <= mem[raddr];
	end
endmodule : krt_store
`default_nettype wire

### tb/sv/krt_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// krt_checker: result predictor and scoreboard for the keyed record table
// Watches the request, config and result channels, keeps its own copy of
// the table and compares every result word field by field, in order.
// ----------------------------------------------------------------------------
module krt_checker (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic                      busy,
	input  wire krt_pkg::req_t             req,
	input  wire logic                      done,
	input  wire krt_pkg::rsp_t             rsp,
	input  wire logic                      cfg_we,
	input  wire logic                      cfg_index,
	input  wire logic [krt_pkg::CntW-1:0]  cfg_data,
	output int                             fails,
	output int                             pending
);
	import krt_pkg::*;

	logic [KeyW-1:0] tbl_key [MaxEntries];
	logic [ValW-1:0] tbl_val [MaxEntries];
	int unsigned     n_used;
	int unsigned     cap_now;
	int unsigned     cap_init;
	int unsigned     step;
	bit              is_sorted;
	rsp_t            rsp_queue [$];

	function automatic int unsigned clamp_cap(input int unsigned v);
		return (v > MaxEntries) ? MaxEntries : v;
	endfunction

	// linear walk, or binary search while sorted
	function automatic bit find_slot(input logic [KeyW-1:0] k, output int unsigned slot,
			output int unsigned probes);
		int unsigned lo, hi, mid;
		slot = 0;
		probes = 0;
		if (!is_sorted) begin
			for (int unsigned i = 0; i < n_used; i++) begin
				probes++;
				if (tbl_key[i] == k) begin
					slot = i;
					return 1;
				end
			end
		end else begin
			lo = 0;
			hi = n_used;
			while (lo < hi) begin
				mid = lo + (hi - lo) / 2;
				if (tbl_key[mid] == k) begin
					slot = mid;
					probes++;
					return 1;
				end
				probes += 2;
				if (tbl_key[mid] > k) hi = mid;
				else lo = mid + 1;
			end
		end
		return 0;
	endfunction

	function automatic int unsigned sort_table();
		int unsigned cnt, j;
		logic [KeyW-1:0] tk;
		logic [ValW-1:0] tv;
		cnt = 0;
		for (int unsigned s = 1; s < n_used; s++) begin
			cnt++;
			if (tbl_key[s-1] < tbl_key[s]) continue;
			cnt++;
			j = s;
			while (j > 0 && tbl_key[j] < tbl_key[j-1]) begin
				tk = tbl_key[j];
				tv = tbl_val[j];
				tbl_key[j] = tbl_key[j-1];
				tbl_val[j] = tbl_val[j-1];
				tbl_key[j-1] = tk;
				tbl_val[j-1] = tv;
				j--;
			end
		end
		is_sorted = 1;
		return cnt;
	endfunction

	function automatic rsp_t apply_request(input req_t r);
		rsp_t        o;
		int unsigned slot, probes, last;
		o = '0;
		probes = 0;
		case (r.mode)
			MODE_INSERT: begin
				if (r.key == 0 || r.value == 0) o.status = ST_ZERO;
				else if (find_slot(r.key, slot, probes)) o.status = ST_MISSING;
				else begin
					if (cap_now <= n_used) cap_now = clamp_cap(cap_now + step);
					if (n_used >= cap_now || n_used >= MaxEntries) o.status = ST_FULL;
					else begin
						tbl_key[n_used] = r.key;
						tbl_val[n_used] = r.value;
						n_used++;
						is_sorted = 0;
					end
				end
				probes = 0;
			end
			MODE_REMOVE: begin
				if (!find_slot(r.key, slot, probes)) o.status = ST_MISSING;
				else begin
					last = n_used - 1;
					if (slot != last) begin
						tbl_key[slot] = tbl_key[last];
						tbl_val[slot] = tbl_val[last];
						is_sorted = 0;
					end
					n_used = last;
					if (cap_now >= step && cap_now - n_used >= step) cap_now -= step;
				end
				probes = 0;
			end
			MODE_MODIFY: begin
				if (r.key == 0 || r.value == 0) o.status = ST_ZERO;
				else if (find_slot(r.key, slot, probes)) tbl_val[slot] = r.value;
				else o.status = ST_MISSING;
				probes = 0;
			end
			MODE_FIND: begin
				if (find_slot(r.key, slot, probes)) o.found_value = tbl_val[slot];
				else o.status = ST_MISSING;
			end
			MODE_SORT: probes = sort_table();
			MODE_CLEAR: begin
				n_used = 0;
				cap_now = 0;
				is_sorted = 0;
			end
			default: ;
		endcase
		o.comparisons = probes[CmpW-1:0];
		o.entry_count = n_used[CntW-1:0];
		o.capacity    = cap_now[CntW-1:0];
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			n_used    = 0;
			cap_init  = 16;
			step      = 16;
			cap_now   = 16;
			is_sorted = 0;
			rsp_queue.delete();
			fails     = 0;
		end else begin
			// result first: a word finishing here belongs to an older request
			if (done) begin
				if (rsp_queue.size() == 0) begin
					$error("result word with no request outstanding: %p", rsp);
					fails++;
				end else begin
					want = rsp_queue.pop_front();
					if (rsp.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, rsp.status);
						fails++;
					end
					if (rsp.found_value !== want.found_value) begin
						$error("found_value: expected %0h, got %0h",
							want.found_value, rsp.found_value);
						fails++;
					end
					if (rsp.comparisons !== want.comparisons) begin
						$error("comparisons: expected %0d, got %0d",
							want.comparisons, rsp.comparisons);
						fails++;
					end
					if (rsp.entry_count !== want.entry_count) begin
						$error("entry_count: expected %0d, got %0d",
							want.entry_count, rsp.entry_count);
						fails++;
					end
					if (rsp.capacity !== want.capacity) begin
						$error("capacity: expected %0d, got %0d", want.capacity, rsp.capacity);
						fails++;
					end
				end
			end
			if (cfg_we) begin
				if (cfg_index == CFG_INIT_CAP) begin
					cap_init = cfg_data;
					if (n_used == 0) cap_now = clamp_cap(cap_init);
				end else begin
					step = cfg_data;
				end
			end
			if (start && !busy) rsp_queue.push_back(apply_request(req));
		end
		pending = rsp_queue.size();
	end
endmodule : krt_checker
`default_nettype wire

### tb/sv/keyed_record_table_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// keyed_record_table_tb: request stimulus for the keyed record table
// Directed corner cases, then three random phases under different capacity
// settings and idle patterns; the checker scores every result word.
// ----------------------------------------------------------------------------
module keyed_record_table_tb;
	import krt_pkg::*;

	// modes the block leaves undefined; they must be no-ops
	localparam logic [2:0] MODE_SPARE_LO = 3'd6;
	localparam logic [2:0] MODE_SPARE_HI = 3'd7;
	localparam int         PoolSize      = 40;

	logic            clk;
	logic            arst_n;
	logic            start;
	logic            busy;
	req_t            req;
	logic            done;
	rsp_t            rsp;
	logic            cfg_we;
	logic            cfg_index;
	logic [CntW-1:0] cfg_data;
	int              fails;
	int              pending;

	logic [KeyW-1:0] key_pool [PoolSize];
	int              idle_pct;
	int              n_words;
	int              n_by_mode [8];

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	keyed_record_table u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.done      (done),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	krt_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.done      (done),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.fails     (fails),
		.pending   (pending)
	);

	// Hold the word on req with start high until an edge sees busy low.
	// busy read right after the edge is still the pre-edge value.
	// start is left high; the next word or an idle stretch replaces it.
	task automatic send_word(input logic [2:0] m, input logic [KeyW-1:0] k,
			input logic [ValW-1:0] v);
		while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start    <= 1'b1;
		req.mode <= m;
		req.key  <= k;
		req.value <= v;
		@(posedge clk);
		while (busy) @(posedge clk);
		n_words++;
		n_by_mode[m]++;
	endtask

	// drain all results, then let the block settle before touching config
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0 || busy) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_config(input logic [CntW-1:0] init_cap, input logic [CntW-1:0] step);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_INIT_CAP;
		cfg_data  <= init_cap;
		@(posedge clk);
		cfg_index <= CFG_GROW_STEP;
		cfg_data  <= step;
		@(posedge clk);
		cfg_we    <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [KeyW-1:0] pick_key();
		int r;
		r = $urandom_range(99);
		if (r < 80) return key_pool[$urandom_range(PoolSize-1)];
		if (r < 84) return '0;
		if (r < 87) return '1;
		return $urandom;
	endfunction

	function automatic logic [ValW-1:0] pick_value();
		int r;
		r = $urandom_range(99);
		if (r < 5) return '0;
		if (r < 9) return '1;
		return ValW'($urandom);
	endfunction

	// mostly inserts and lookups on a small key pool so hits, duplicates,
	// sorted searches and shrink all happen; clears keep the table short
	task automatic random_words(input int count);
		int r;
		logic [2:0] m;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(99);
			if (r < 34) m = MODE_INSERT;
			else if (r < 50) m = MODE_REMOVE;
			else if (r < 61) m = MODE_MODIFY;
			else if (r < 88) m = MODE_FIND;
			else if (r < 95) m = MODE_SORT;
			else if (r < 97) m = MODE_CLEAR;
			else m = $urandom_range(0, 1) ? MODE_SPARE_LO : MODE_SPARE_HI;
			send_word(m, pick_key(), pick_value());
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		start     = 1'b0;
		req       = '0;
		cfg_we    = 1'b0;
		cfg_index = CFG_INIT_CAP;
		cfg_data  = '0;
		idle_pct  = 33;
		n_words   = 0;
		foreach (n_by_mode[i]) n_by_mode[i] = 0;
		foreach (key_pool[i]) key_pool[i] = $urandom | 32'h1;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ---- directed corners at reset settings ----
		send_word(MODE_FIND, key_pool[0], 16'h0);           // empty table
		send_word(MODE_INSERT, '0, 16'h1234);               // zero key
		send_word(MODE_INSERT, key_pool[0], '0);            // zero value
		send_word(MODE_INSERT, '1, '1);                     // max key and value
		send_word(MODE_INSERT, key_pool[0], 16'h0001);
		send_word(MODE_INSERT, key_pool[1], 16'h8000);
		send_word(MODE_INSERT, key_pool[0], 16'h5555);      // duplicate
		send_word(MODE_MODIFY, key_pool[1], 16'hAAAA);
		send_word(MODE_MODIFY, key_pool[1], '0);            // zero value
		send_word(MODE_MODIFY, key_pool[5], 16'h7);         // missing
		send_word(MODE_FIND, key_pool[1], '1);              // linear hit
		send_word(MODE_FIND, key_pool[6], '0);              // linear miss
		send_word(MODE_SORT, '0, '0);
		send_word(MODE_FIND, '1, '0);                       // binary hit
		send_word(MODE_FIND, key_pool[7], '0);              // binary miss
		send_word(MODE_REMOVE, '1, '0);                     // last slot keeps sorted
		send_word(MODE_FIND, key_pool[0], '0);
		send_word(MODE_REMOVE, key_pool[8], '0);            // missing
		send_word(MODE_SPARE_LO, '1, '1);
		send_word(MODE_SPARE_HI, '1, '1);
		send_word(MODE_CLEAR, '0, '0);
		send_word(MODE_INSERT, key_pool[2], 16'h3);         // grows from zero capacity
		send_word(MODE_SORT, '0, '0);                       // single entry
		drain();

		// ---- phase A: nominal settings ----
		set_config(9'd16, 9'd16);
		random_words(500);
		drain();

		// ---- phase B: zero start capacity, unit step ----
		idle_pct = 55;
		send_word(MODE_CLEAR, '0, '0);
		drain();
		set_config(9'd0, 9'd1);
		random_words(500);
		drain();

		// ---- phase C: oversize capacity (clamped), max step, full table ----
		idle_pct = 0;
		send_word(MODE_CLEAR, '0, '0);
		drain();
		set_config(9'd511, 9'd256);
		for (int i = 0; i < 258; i++)
			send_word(MODE_INSERT, $urandom | 32'h1, ValW'($urandom) | 16'h1);
		send_word(MODE_FIND, key_pool[3], '0);              // full-length linear miss
		send_word(MODE_SORT, '0, '0);                       // full-size sort
		send_word(MODE_FIND, key_pool[3], '0);              // full-depth binary miss
		send_word(MODE_CLEAR, '0, '0);
		drain();
		set_config(9'd256, 9'd7);
		random_words(500);
		drain();
		repeat (20) @(posedge clk);

		$display("Sent %0d request words: %0d insert, %0d remove, %0d modify, %0d find,",
			n_words, n_by_mode[MODE_INSERT], n_by_mode[MODE_REMOVE],
			n_by_mode[MODE_MODIFY], n_by_mode[MODE_FIND]);
		$display("  %0d sort, %0d clear, %0d spare-mode, over three capacity settings.",
			n_by_mode[MODE_SORT], n_by_mode[MODE_CLEAR],
			n_by_mode[MODE_SPARE_LO] + n_by_mode[MODE_SPARE_HI]);
		if (fails == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	// watchdog: covers every sort running at full table size
	initial begin
		#400000000;
		$display("timeout with %0d results outstanding", pending);
		$display("== FAIL ==");
		$finish;
	end
endmodule : keyed_record_table_tb
`default_nettype wire
